// File: design/gas_pkg.sv
package gas_pkg;

   localparam int MAX_GROUP_DEF   = 65536;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int SAMPLE_W = 24;
   localparam int VALUE_W  = 64;
   localparam int MODE_W   = 4;
   localparam int COUNT_W  = 17;

   localparam logic [MODE_W-1:0] MODE_COUNT   = 4'd0;
   localparam logic [MODE_W-1:0] MODE_ANY     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_ALL     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_NTRUE   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_NFALSE  = 4'd4;
   localparam logic [MODE_W-1:0] MODE_MIN     = 4'd5;
   localparam logic [MODE_W-1:0] MODE_MAX     = 4'd6;
   localparam logic [MODE_W-1:0] MODE_SUM     = 4'd7;
   localparam logic [MODE_W-1:0] MODE_PRODUCT = 4'd8;
   localparam logic [MODE_W-1:0] MODE_SUMSQ   = 4'd9;
   localparam logic [MODE_W-1:0] MODE_MEAN    = 4'd10;
   localparam logic [MODE_W-1:0] MODE_VAR     = 4'd11;
   localparam logic [MODE_W-1:0] MODE_STD     = 4'd12;
   localparam logic [MODE_W-1:0] MODE_RMS     = 4'd13;

   localparam logic [VALUE_W-1:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] INT64_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
      logic [VALUE_W-1:0] acc;
      logic [VALUE_W-1:0] sq;
      logic               ovf;
   } entry_type;

   function automatic logic [VALUE_W-1:0] start_value(input logic [MODE_W-1:0] md);
      logic [VALUE_W-1:0] v;
      case (md)
         MODE_ALL, MODE_PRODUCT: v = 64'd1;
         MODE_MIN:               v = INT64_MAX;
         MODE_MAX:               v = INT64_MIN;
         default:                v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: design/gas_queue.sv
module gas_queue
   import gas_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         mem[wptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/gas_front.sv
module gas_front
   import gas_pkg::*;
#(
   parameter int MAX_GROUP   = MAX_GROUP_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last,
   input  logic [MODE_W-1:0]   mode,
   input  logic                q_full,
   output logic                push,
   output entry_type           push_entry
);

   localparam int CNT_W = $clog2(MAX_GROUP + 1);

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_UPD} state_type;

   state_type                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0] s_ff, s_in;
   logic                       last_ff, last_in;
   logic [MODE_W-1:0]          mode_ff, mode_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [VALUE_W-1:0]         acc_ff, acc_in;
   logic [VALUE_W-1:0]         sq_ff, sq_in;
   logic                       ovf_ff, ovf_in;
   logic [VALUE_W-1:0]         plo_ff, plo_in;
   logic [31:0]                phi_ff, phi_in;
   logic [VALUE_W-1:0]         psq_ff, psq_in;

   logic [VALUE_W-1:0]         acc_src;
   logic signed [56:0]         mul_lo, mul_hi;
   logic signed [47:0]         mul_sq;
   logic [VALUE_W-1:0]         s64, acc_new, product;
   logic [CNT_W-1:0]           cnt_nx;
   logic [VALUE_W-1:0]         acc_nx, sq_nx;
   logic                       ovf_nx;

   assign req_ready = (state_ff == F_IDLE) && !q_full;

   assign acc_src = (cnt_ff == '0) ? start_value(mode_ff) : acc_ff;
   assign mul_lo  = $signed({1'b0, acc_src[31:0]}) * s_ff;
   assign mul_hi  = $signed({1'b0, acc_src[63:32]}) * s_ff;
   assign mul_sq  = s_ff * s_ff;
   assign s64     = VALUE_W'(s_ff);
   assign product = plo_ff + {phi_ff, 32'b0};

   always_comb begin
      case (mode_ff)
         MODE_ANY:    acc_new = (s_ff != '0) ? 64'd1 : acc_ff;
         MODE_ALL:    acc_new = (s_ff == '0) ? 64'd0 : acc_ff;
         MODE_NTRUE:  acc_new = acc_ff + VALUE_W'(s_ff != '0);
         MODE_NFALSE: acc_new = acc_ff + VALUE_W'(s_ff == '0);
         MODE_MIN:    acc_new = ($signed(s64) < $signed(acc_ff)) ? s64 : acc_ff;
         MODE_MAX:    acc_new = ($signed(s64) > $signed(acc_ff)) ? s64 : acc_ff;
         MODE_SUM, MODE_MEAN, MODE_VAR, MODE_STD: acc_new = acc_ff + s64;
         MODE_PRODUCT: acc_new = product;
         MODE_SUMSQ, MODE_RMS: acc_new = acc_ff + psq_ff;
         default:     acc_new = acc_ff + 64'd1;
      endcase
   end

   always_comb begin
      if (cnt_ff < CNT_W'(MAX_GROUP)) begin
         acc_nx = acc_new;
         sq_nx  = sq_ff + psq_ff;
         cnt_nx = cnt_ff + CNT_W'(1);
         ovf_nx = ovf_ff;
      end else begin
         acc_nx = acc_ff;
         sq_nx  = sq_ff;
         cnt_nx = cnt_ff;
         ovf_nx = 1'b1;
      end
   end

   assign push             = (state_ff == F_UPD) && last_ff;
   assign push_entry.mode  = mode_ff;
   assign push_entry.count = COUNT_W'(cnt_nx);
   assign push_entry.acc   = acc_nx;
   assign push_entry.sq    = sq_nx;
   assign push_entry.ovf   = ovf_nx;

   always_comb begin
      state_in = state_ff;
      s_in     = s_ff;
      last_in  = last_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      sq_in    = sq_ff;
      ovf_in   = ovf_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      psq_in   = psq_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               s_in     = SAMPLE_W'($signed(req_sample[SAMPLE_BITS-1:0]));
               last_in  = req_last;
               mode_in  = mode;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            acc_in   = acc_src;
            plo_in   = VALUE_W'(mul_lo);
            phi_in   = mul_hi[31:0];
            psq_in   = VALUE_W'(mul_sq);
            state_in = F_UPD;
         end
         F_UPD: begin
            if (last_ff) begin
               cnt_in = '0;
               acc_in = '0;
               sq_in  = '0;
               ovf_in = 1'b0;
            end else begin
               cnt_in = cnt_nx;
               acc_in = acc_nx;
               sq_in  = sq_nx;
               ovf_in = ovf_nx;
            end
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         sq_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         sq_ff    <= sq_in;
         ovf_ff   <= ovf_in;
      end
      s_ff    <= s_in;
      last_ff <= last_in;
      mode_ff <= mode_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      psq_ff  <= psq_in;
   end

endmodule

// File: design/gas_back.sv
module gas_back
   import gas_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  entry_type          head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_overflow
);

   localparam int DIV_W = 2 * COUNT_W;
   localparam int X_W   = 128;
   localparam int SR_W  = 68;

   typedef enum logic [2:0] {B_IDLE, B_MUL, B_SUB, B_DIV, B_SQRT, B_FIN, B_OUT} state_type;

   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [VALUE_W-1:0] m_ff, m_in;
   logic [VALUE_W-1:0] sq_ff, sq_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;
   logic [DIV_W-1:0]   d_ff, d_in;
   logic [X_W-1:0]     s2_ff, s2_in, nq_ff, nq_in;
   logic [63:0]        prod_ff, prod_in;
   logic [2:0]         step_ff, step_in;
   logic [X_W-1:0]     x_ff, x_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [6:0]         iter_ff, iter_in;
   logic [63:0]        root_ff, root_in;
   logic [SR_W-1:0]    srem_ff, srem_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   logic [COUNT_W-1:0] n_sel;
   logic [VALUE_W-1:0] m_sel;
   logic [31:0]        op_a, op_b;
   logic [X_W-1:0]     num;
   logic [DIV_W:0]     rem_sh;
   logic               div_ge;
   logic [SR_W-1:0]    srem_sh, trial;
   logic               sq_ge;

   assign n_sel  = (head.count == '0) ? COUNT_W'(1) : head.count;
   assign m_sel  = head.acc[63] ? (~head.acc + 64'd1) : head.acc;
   assign num    = (nq_ff >= s2_ff) ? (nq_ff - s2_ff) : '0;
   assign rem_sh = {rem_ff, x_ff[X_W-1]};
   assign div_ge = (rem_sh >= {1'b0, d_ff});
   assign srem_sh = {srem_ff[SR_W-3:0], x_ff[X_W-1:X_W-2]};
   assign trial   = SR_W'({root_ff, 2'b01});
   assign sq_ge   = (srem_sh >= trial);

   assign pop          = (state_ff == B_IDLE) && head_valid;
   assign rsp_valid    = (state_ff == B_OUT);
   assign rsp_value    = value_ff;
   assign rsp_overflow = ovf_ff;

   always_comb begin
      case (step_ff)
         3'd0:    begin op_a = m_ff[31:0];  op_b = m_ff[31:0];  end
         3'd1:    begin op_a = m_ff[31:0];  op_b = m_ff[63:32]; end
         3'd2:    begin op_a = m_ff[63:32]; op_b = m_ff[31:0];  end
         3'd3:    begin op_a = m_ff[63:32]; op_b = m_ff[63:32]; end
         3'd4:    begin op_a = 32'(n_ff);   op_b = sq_ff[31:0];  end
         3'd5:    begin op_a = 32'(n_ff);   op_b = sq_ff[63:32]; end
         default: begin op_a = '0;          op_b = '0;           end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      sq_in    = sq_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      d_in     = d_ff;
      s2_in    = s2_ff;
      nq_in    = nq_ff;
      prod_in  = prod_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      iter_in  = iter_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      value_in = value_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               mode_in = head.mode;
               n_in    = n_sel;
               m_in    = m_sel;
               sq_in   = head.sq;
               neg_in  = head.acc[63];
               ovf_in  = head.ovf;
               rem_in  = '0;
               iter_in = '0;
               step_in = '0;
               s2_in   = '0;
               nq_in   = '0;
               root_in = '0;
               srem_in = '0;
               if (head.mode == MODE_VAR || head.mode == MODE_STD) begin
                  d_in = DIV_W'(n_sel) * DIV_W'(n_sel - COUNT_W'(1));
               end else begin
                  d_in = DIV_W'(n_sel);
               end
               case (head.mode)
                  MODE_MEAN: begin
                     x_in     = {48'b0, m_sel, 16'b0};
                     state_in = B_DIV;
                  end
                  MODE_VAR, MODE_STD: begin
                     if (n_sel < COUNT_W'(2)) begin
                        value_in = '0;
                        state_in = B_OUT;
                     end else begin
                        state_in = B_MUL;
                     end
                  end
                  MODE_RMS: begin
                     x_in     = {32'b0, head.sq, 32'b0};
                     state_in = B_DIV;
                  end
                  default: begin
                     value_in = head.acc;
                     state_in = B_OUT;
                  end
               endcase
            end
         end
         B_MUL: begin
            prod_in = op_a * op_b;
            case (step_ff)
               3'd1: s2_in = s2_ff + X_W'(prod_ff);
               3'd2: s2_in = s2_ff + (X_W'(prod_ff) << 32);
               3'd3: s2_in = s2_ff + (X_W'(prod_ff) << 32);
               3'd4: s2_in = s2_ff + (X_W'(prod_ff) << 64);
               3'd5: nq_in = nq_ff + X_W'(prod_ff);
               3'd6: nq_in = nq_ff + (X_W'(prod_ff) << 32);
               default: s2_in = s2_ff;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               state_in = B_SUB;
            end
         end
         B_SUB: begin
            x_in     = (mode_ff == MODE_VAR) ? (num << 16) : (num << 32);
            state_in = B_DIV;
         end
         B_DIV: begin
            rem_in  = div_ge ? DIV_W'(rem_sh - {1'b0, d_ff}) : DIV_W'(rem_sh);
            x_in    = {x_ff[X_W-2:0], div_ge};
            iter_in = iter_ff + 7'd1;
            if (iter_ff == 7'd127) begin
               iter_in  = '0;
               state_in = (mode_ff == MODE_STD || mode_ff == MODE_RMS) ? B_SQRT : B_FIN;
            end
         end
         B_SQRT: begin
            srem_in = sq_ge ? (srem_sh - trial) : srem_sh;
            root_in = {root_ff[62:0], sq_ge};
            x_in    = {x_ff[X_W-3:0], 2'b00};
            iter_in = iter_ff + 7'd1;
            if (iter_ff == 7'd63) begin
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            case (mode_ff)
               MODE_MEAN: begin
                  if (!neg_ff) begin
                     value_in = (x_ff[X_W-1:63] != '0) ? INT64_MAX : x_ff[63:0];
                  end else if (x_ff[X_W-1:64] != '0 || (x_ff[63] && x_ff[62:0] != '0)) begin
                     value_in = INT64_MIN;
                  end else begin
                     value_in = ~x_ff[63:0] + 64'd1;
                  end
               end
               MODE_VAR: value_in = (x_ff[X_W-1:63] != '0) ? INT64_MAX : x_ff[63:0];
               default:  value_in = root_ff[63] ? INT64_MAX : root_ff;
            endcase
            state_in = B_OUT;
         end
         B_OUT: begin
            if (rsp_ready) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff  <= mode_in;
      n_ff     <= n_in;
      m_ff     <= m_in;
      sq_ff    <= sq_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      d_ff     <= d_in;
      s2_ff    <= s2_in;
      nq_ff    <= nq_in;
      prod_ff  <= prod_in;
      step_ff  <= step_in;
      x_ff     <= x_in;
      rem_ff   <= rem_in;
      iter_ff  <= iter_in;
      root_ff  <= root_in;
      srem_ff  <= srem_in;
      value_ff <= value_in;
   end

endmodule

// File: design/group_aggregate_statistics.sv
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_sample, req_last
// rsp       out        rsp_valid, rsp_ready, rsp_value, rsp_overflow
// csr       in         csr_valid, csr_ready, csr_data
//
// Each request passes through the front-end capture, partial-product and update states in turn.
// An integer-mode result goes from the queue straight to the output; mean adds the 128-step
// radix-2 divider and a saturation step, variance also the partial products and subtraction,
// and stddev and rms add the 64-step square root.
// A two-entry queue lets the next group flow in; a held result stalls the queue and then req.
// Synchronous active-high reset clears all group state; the mode register resets to count.
module group_aggregate_statistics
   import gas_pkg::*;
#(
   parameter int MAX_GROUP   = MAX_GROUP_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic                rsp_overflow,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [MODE_W-1:0]   csr_data
);

   logic [MODE_W-1:0] mode_ff;
   logic              q_full, push, pop, head_valid;
   entry_type         push_entry, head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COUNT;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   gas_front #(
      .MAX_GROUP   (MAX_GROUP),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_last   (req_last),
      .mode       (mode_ff),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   gas_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   gas_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow)
   );

endmodule
